// ===== rtl/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHECK_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define CHECK_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define CHECK_IMPL(label, clk, rst, a, c, msg)
`define CHECK_NEXT(label, clk, rst, a, c, msg)
`endif
`endif

// ===== rtl/msrpn_pkg.sv =====
`timescale 1ns / 1ps
package msrpn_pkg;
  localparam int NUM_STACKS = 8;
  localparam int STACK_DEPTH = 256;
  localparam int STACK_LIMIT = (NUM_STACKS < 8) ? NUM_STACKS : 8;
  localparam int SW = (STACK_LIMIT > 1) ? $clog2(STACK_LIMIT) : 1;
  localparam int CW = $clog2(STACK_LIMIT + 1);
  localparam int DW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int AW = SW + DW;

  localparam logic [2:0] K_CREATE = 3'd0;
  localparam logic [2:0] K_PUSH   = 3'd1;
  localparam logic [2:0] K_POP    = 3'd2;
  localparam logic [2:0] K_ADD    = 3'd3;
  localparam logic [2:0] K_SUB    = 3'd4;
  localparam logic [2:0] K_NEG    = 3'd5;
  localparam logic [2:0] K_MAX    = 3'd6;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BAD   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_ROOM  = 3'd4;

  // datapath commands
  typedef enum logic [2:0] {
    OP_NONE, OP_RD, OP_WR_VAL, OP_WR_SUM, OP_WR_NEG, OP_CLR_BEST, OP_BEST
  } op_t;

  typedef struct packed {
    op_t            op;
    logic [AW-1:0]  addr;
    logic           sub;
    logic           latch_a;
  } cmd_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [31:0] best;
  } stat_t;

  function automatic logic [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'h7fffffff;
    if (v < -33'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction
endpackage

// ===== rtl/msrpn_if.sv =====
`timescale 1ns / 1ps
interface msrpn_in_if (input logic clk);
  logic valid, ready;
  logic [2:0] kind;
  logic [2:0] stack_index;
  logic signed [31:0] value;
  modport source (output valid, kind, stack_index, value, input ready);
  modport sink (input valid, kind, stack_index, value, output ready);
endinterface

interface msrpn_out_if (input logic clk);
  logic valid, ready;
  logic [2:0] out_stack;
  logic signed [31:0] max_value;
  logic is_empty;
  logic [2:0] status;
  logic last;
  modport source (output valid, out_stack, max_value, is_empty, status, last, input ready);
  modport sink (input valid, out_stack, max_value, is_empty, status, last, output ready);
endinterface

// ===== rtl/msrpn_datapath.sv =====
`timescale 1ns / 1ps
module msrpn_datapath (
  input  logic                  clk,
  input  msrpn_pkg::cmd_t       cmd,
  input  logic [31:0]           wval,
  output msrpn_pkg::stat_t      stat
);
  logic [31:0] mem [2**msrpn_pkg::AW];
  logic [31:0] rdata, opa, best;
  logic signed [32:0] sum;
  logic [31:0] wdata;

  // saturating combine of last read (lower entry) and latched operand (top entry), or negate of last read
  always_comb begin
    sum = cmd.sub ? ($signed({rdata[31], rdata}) - $signed({opa[31], opa}))
                  : ($signed({rdata[31], rdata}) + $signed({opa[31], opa}));
    case (cmd.op)
      msrpn_pkg::OP_WR_SUM: wdata = msrpn_pkg::sat33(sum);
      msrpn_pkg::OP_WR_NEG: wdata = msrpn_pkg::sat33(33'sd0 - $signed({rdata[31], rdata}));
      default:              wdata = wval;
    endcase
  end

  // memory port and operand registers
  always_ff @(posedge clk) begin
    if (cmd.op == msrpn_pkg::OP_WR_VAL || cmd.op == msrpn_pkg::OP_WR_SUM ||
        cmd.op == msrpn_pkg::OP_WR_NEG) begin
      mem[cmd.addr] <= wdata;
    end
    if (cmd.op == msrpn_pkg::OP_RD) rdata <= mem[cmd.addr];
    if (cmd.latch_a) opa <= rdata;
    if (cmd.op == msrpn_pkg::OP_CLR_BEST) best <= rdata;
    else if (cmd.op == msrpn_pkg::OP_BEST && $signed(rdata) > $signed(best)) best <= rdata;
  end

  assign stat.rdata = rdata;
  assign stat.best = best;
endmodule

// ===== rtl/msrpn_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module msrpn_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  msrpn_in_if.sink             in_ch,
  msrpn_out_if.source          out_ch,
  output msrpn_pkg::cmd_t      cmd,
  output logic [31:0]          wval,
  input  msrpn_pkg::stat_t     stat
);
  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_BC_NEXT, S_BC_RD1, S_BC_W1, S_BC_RD2, S_BC_W2, S_BC_CALC,
    S_MX_NEXT, S_MX_W0, S_MX_RD, S_MX_W, S_MX_FIN, S_MX_EMIT, S_OUT
  } state_t;

  state_t state;
  logic [2:0] kind, idx;
  logic [31:0] val;
  logic [msrpn_pkg::CW-1:0] count;
  logic [msrpn_pkg::FW-1:0] fill [msrpn_pkg::STACK_LIMIT];
  logic [msrpn_pkg::SW-1:0] s;
  logic [msrpn_pkg::FW-1:0] i;
  logic ovalid, olast, oempty;
  logic [2:0] ostack, ostatus;
  logic [31:0] omax;
  logic [msrpn_pkg::FW-1:0] fs;
  logic idx_ok;
  logic [msrpn_pkg::CW-1:0] s_ext;

  assign fs = fill[s];
  assign s_ext = msrpn_pkg::CW'(s);
  assign idx_ok = ({1'b0, idx} < 4'(count));
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = ovalid;
  assign out_ch.out_stack = ostack;
  assign out_ch.max_value = omax;
  assign out_ch.is_empty = oempty;
  assign out_ch.status = ostatus;
  assign out_ch.last = olast;
  assign wval = val;

  // stack address of stack s, entry e
  function automatic logic [msrpn_pkg::AW-1:0] ad(input logic [msrpn_pkg::SW-1:0] st,
                                                  input logic [msrpn_pkg::FW-1:0] e);
    return {st, e[msrpn_pkg::DW-1:0]};
  endfunction

  // sequencer
  always_ff @(posedge clk) begin
    cmd <= '{op: msrpn_pkg::OP_NONE, addr: '0, sub: 1'b0, latch_a: 1'b0};
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ovalid <= 1'b0;
      for (int k = 0; k < msrpn_pkg::STACK_LIMIT; k++) fill[k] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            kind <= in_ch.kind;
            idx <= in_ch.stack_index;
            val <= in_ch.value;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          omax <= '0; ostack <= '0; ostatus <= msrpn_pkg::ST_OK;
          oempty <= 1'b0; olast <= 1'b1; s <= '0;
          state <= S_OUT;
          case (kind)
            msrpn_pkg::K_CREATE: begin
              if (32'(count) >= msrpn_pkg::STACK_LIMIT) ostatus <= msrpn_pkg::ST_ROOM;
              else begin
                fill[count[msrpn_pkg::SW-1:0]] <= '0;
                ostack <= 3'(count);
                oempty <= 1'b1;
                count <= count + 1'b1;
              end
            end
            msrpn_pkg::K_PUSH, msrpn_pkg::K_POP: begin
              ostack <= idx;
              if (!idx_ok) begin
                ostatus <= msrpn_pkg::ST_BAD; oempty <= 1'b1;
              end else if (kind == msrpn_pkg::K_PUSH) begin
                if (32'(fill[idx[msrpn_pkg::SW-1:0]]) >= msrpn_pkg::STACK_DEPTH)
                  ostatus <= msrpn_pkg::ST_FULL;
                else begin
                  cmd.op <= msrpn_pkg::OP_WR_VAL;
                  cmd.addr <= ad(idx[msrpn_pkg::SW-1:0], fill[idx[msrpn_pkg::SW-1:0]]);
                  fill[idx[msrpn_pkg::SW-1:0]] <= fill[idx[msrpn_pkg::SW-1:0]] + 1'b1;
                end
              end else begin
                if (fill[idx[msrpn_pkg::SW-1:0]] == '0) begin
                  ostatus <= msrpn_pkg::ST_EMPTY; oempty <= 1'b1;
                end else begin
                  fill[idx[msrpn_pkg::SW-1:0]] <= fill[idx[msrpn_pkg::SW-1:0]] - 1'b1;
                  oempty <= (fill[idx[msrpn_pkg::SW-1:0]] == msrpn_pkg::FW'(1));
                end
              end
            end
            msrpn_pkg::K_ADD, msrpn_pkg::K_SUB, msrpn_pkg::K_NEG:
              state <= (count == '0) ? S_OUT : S_BC_NEXT;
            msrpn_pkg::K_MAX: begin
              if (count == '0) begin
                oempty <= 1'b1; ostatus <= msrpn_pkg::ST_BAD;
              end else state <= S_MX_NEXT;
            end
            default: state <= S_IDLE;
          endcase
        end
        // broadcast: walk open stacks
        S_BC_NEXT: begin
          if (kind == msrpn_pkg::K_NEG ? fs != '0 : fs >= msrpn_pkg::FW'(2)) begin
            cmd.op <= msrpn_pkg::OP_RD;
            cmd.addr <= ad(s, fs - 1'b1);
            state <= S_BC_RD1;
          end else state <= S_BC_CALC;
        end
        S_BC_RD1: state <= S_BC_W1;
        S_BC_W1: begin
          if (kind == msrpn_pkg::K_NEG) begin
            cmd.op <= msrpn_pkg::OP_WR_NEG;
            cmd.addr <= ad(s, fs - 1'b1);
            state <= S_BC_CALC;
          end else begin
            cmd.latch_a <= 1'b1;
            state <= S_BC_RD2;
          end
        end
        S_BC_RD2: begin
          cmd.op <= msrpn_pkg::OP_RD;
          cmd.addr <= ad(s, fs - 2'd2);
          state <= S_BC_W2;
        end
        S_BC_W2: state <= S_MX_FIN;
        S_MX_FIN: begin
          if (kind == msrpn_pkg::K_MAX) begin
            state <= S_MX_EMIT;
          end else begin
            // opa holds b (top), rdata a (lower); compute rdata(a) op opa(b)
            cmd.op <= msrpn_pkg::OP_WR_SUM;
            cmd.sub <= (kind == msrpn_pkg::K_SUB);
            cmd.addr <= ad(s, fs - 2'd2);
            fill[s] <= fs - 1'b1;
            state <= S_BC_CALC;
          end
        end
        S_BC_CALC: begin
          if (s_ext + 1'b1 >= count) state <= S_OUT;
          else begin
            s <= s + 1'b1; state <= S_BC_NEXT;
          end
        end
        // max: scan entries of stack s
        S_MX_NEXT: begin
          i <= '0;
          if (fs == '0) state <= S_MX_EMIT;
          else begin
            cmd.op <= msrpn_pkg::OP_RD;
            cmd.addr <= ad(s, '0);
            state <= S_MX_W0;
          end
        end
        S_MX_W0: begin
          cmd.op <= msrpn_pkg::OP_CLR_BEST;
          i <= msrpn_pkg::FW'(1);
          state <= S_MX_RD;
        end
        S_MX_RD: begin
          if (i >= fs) state <= S_MX_FIN;
          else begin
            cmd.op <= msrpn_pkg::OP_RD;
            cmd.addr <= ad(s, i);
            state <= S_MX_W;
          end
        end
        S_MX_W: begin
          cmd.op <= msrpn_pkg::OP_BEST;
          i <= i + 1'b1;
          state <= S_MX_RD;
        end
        S_MX_EMIT: begin
          if (!ovalid) begin
            ovalid <= 1'b1;
            ostack <= 3'(s);
            omax <= (fs == '0) ? 32'd0 : stat.best;
            oempty <= (fs == '0);
            ostatus <= msrpn_pkg::ST_OK;
            olast <= (s_ext + 1'b1 == count);
          end else if (out_ch.ready) begin
            ovalid <= 1'b0;
            if (olast) state <= S_IDLE;
            else begin
              s <= s + 1'b1; state <= S_MX_NEXT;
            end
          end
        end
        S_OUT: begin
          if (!ovalid) ovalid <= 1'b1;
          else if (out_ch.ready) begin
            ovalid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHECK_IMPL(a_busy_no_ready, clk, rst, state != S_IDLE, !in_ch.ready, "ready while busy")
  `CHECK_IMPL(a_count_max, clk, rst, 1'b1, 32'(count) <= msrpn_pkg::STACK_LIMIT, "count over limit")
  `CHECK_NEXT(a_out_done, clk, rst, ovalid && out_ch.ready && olast, !ovalid, "valid after last")
endmodule

// ===== rtl/multi_stack_rpn_calculator_unit.sv =====
`timescale 1ns / 1ps
// Operand stack bank for a Q16.16 reverse Polish calculator.
// in_ch carries one command word (kind, stack_index, value); out_ch returns
// result words (out_stack, max_value, is_empty, status, last).
// Commands are taken one at a time: ready is high only between commands.
// Create, push and pop pass through decode, then the output handshake.
// Add and subtract combine the top two entries of each open stack and negate
// flips the top entry, all paced by the single port of the entry memory.
// Max scans each open stack entry by entry
// and hands out one word per stack with last on the final one.
// When the receiver stalls, the result word holds and no command is taken.
// Reset (rst, synchronous) closes all stacks; the entry memory needs no clearing.
module multi_stack_rpn_calculator_unit (
  input logic clk,
  input logic rst,
  msrpn_in_if.sink in_ch,
  msrpn_out_if.source out_ch
);
  msrpn_pkg::cmd_t cmd;
  msrpn_pkg::stat_t stat;
  logic [31:0] wval;

  msrpn_ctrl u_ctrl (.clk, .rst, .in_ch, .out_ch, .cmd, .wval, .stat);
  msrpn_datapath u_dp (.clk, .cmd, .wval, .stat);
endmodule
